// ===== rtl/cjsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cjsd_pkg
// Types and constants shared by the canonical JSON string decoder modules.
// ----------------------------------------------------------------------------
package cjsd_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       buffer_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [3:0] error_code;
		logic       run_last;
	} out_item_t;

	// All results caused by one input item: decoded bytes first, then at
	// most one done or error result.
	typedef struct packed {
		logic [2:0]      n_bytes;
		logic [3:0][7:0] bytes;
		logic            has_tail;
		logic [1:0]      tail_kind;
		logic [3:0]      tail_code;
	} bundle_t;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_NO_QUOTE  = 4'd1;
	localparam logic [3:0] ERR_RAW_CHAR  = 4'd2;
	localparam logic [3:0] ERR_UTF8      = 4'd3;
	localparam logic [3:0] ERR_RAW_SEP   = 4'd4;
	localparam logic [3:0] ERR_ESC_END   = 4'd5;
	localparam logic [3:0] ERR_ESC_CHAR  = 4'd6;
	localparam logic [3:0] ERR_HEX_TRUNC = 4'd7;
	localparam logic [3:0] ERR_HEX_CASE  = 4'd8;
	localparam logic [3:0] ERR_HEX_VALUE = 4'd9;
	localparam logic [3:0] ERR_UNTERM    = 4'd10;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage
`default_nettype wire

// ===== rtl/canonical_json_string_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// canonical_json_string_decoder_core
// Strict JSON string decoder with UTF-8 validation, one byte per cycle.
// ----------------------------------------------------------------------------
// Results of a byte pass the bundle queue write, then the output register.
// Throughput: one byte per cycle while the bundle queue has room; a byte with
// k results gives k output items; the four-entry queue absorbs the difference.
// Reset: arst_n clears parser state, queue and output; the parser then waits
// for an opening quote.
module canonical_json_string_decoder_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  cjsd_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  wire                 out_ready,
	output cjsd_pkg::out_item_t out_item
);

	logic              fire;
	logic              push;
	logic              pop;
	logic              full;
	logic              head_valid;
	cjsd_pkg::bundle_t bundle;
	cjsd_pkg::bundle_t head;

	assign in_ready = !full;
	assign fire     = in_valid && in_ready;

	cjsd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (in_item),
		.push   (push),
		.bundle (bundle)
	);

	cjsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_data    (bundle),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	cjsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

endmodule
`default_nettype wire

// ===== rtl/cjsd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cjsd_front
// Parser state machine: classifies each byte and builds its result bundle.
// ----------------------------------------------------------------------------
module cjsd_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 fire,
	input  cjsd_pkg::in_item_t  item,
	output logic                push,
	output cjsd_pkg::bundle_t   bundle
);

	typedef enum logic [2:0] {
		PH_WAIT,
		PH_STR,
		PH_UTF,
		PH_ESC,
		PH_HEX,
		PH_IDLE
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [23:0] held_q, held_d;
	logic [2:0]  seq_len_q, seq_len_d;
	logic [1:0]  seq_idx_q, seq_idx_d;
	logic [15:0] hex_q, hex_d;
	logic [2:0]  hex_cnt_q, hex_cnt_d;
	logic        hex_bad_q, hex_bad_d;

	logic [7:0]  b;
	logic        ok;
	logic [3:0]  dig;
	logic        dig_ok;
	logic        html, sep, ctl;
	cjsd_pkg::bundle_t bnd;

	assign b = item.data_byte;

	always_comb begin
		phase_d   = phase_q;
		held_d    = held_q;
		seq_len_d = seq_len_q;
		seq_idx_d = seq_idx_q;
		hex_d     = hex_q;
		hex_cnt_d = hex_cnt_q;
		hex_bad_d = hex_bad_q;
		bnd       = '0;
		ok        = 1'b0;
		dig       = 4'd0;
		dig_ok    = 1'b0;
		html      = 1'b0;
		sep       = 1'b0;
		ctl       = 1'b0;

		unique case (phase_q)
			PH_WAIT: begin
				if (b == 8'h22) begin
					phase_d = PH_STR;
				end else begin
					bnd.has_tail  = 1'b1;
					bnd.tail_kind = cjsd_pkg::KIND_ERR;
					bnd.tail_code = cjsd_pkg::ERR_NO_QUOTE;
					phase_d       = PH_IDLE;
				end
			end
			PH_STR: begin
				if (b == 8'h22) begin
					bnd.has_tail  = 1'b1;
					bnd.tail_kind = cjsd_pkg::KIND_DONE;
					phase_d       = PH_IDLE;
				end else if (b == 8'h5c) begin
					phase_d = PH_ESC;
				end else if (b < 8'h20 || b == 8'h3c || b == 8'h3e || b == 8'h26) begin
					bnd.has_tail  = 1'b1;
					bnd.tail_kind = cjsd_pkg::KIND_ERR;
					bnd.tail_code = cjsd_pkg::ERR_RAW_CHAR;
					phase_d       = PH_IDLE;
				end else if (!b[7]) begin
					bnd.n_bytes  = 3'd1;
					bnd.bytes[0] = b;
				end else if (b >= 8'hc2 && b <= 8'hf4) begin
					seq_len_d = (b <= 8'hdf) ? 3'd2 : ((b <= 8'hef) ? 3'd3 : 3'd4);
					seq_idx_d = 2'd1;
					held_d    = {16'h0000, b};
					phase_d   = PH_UTF;
				end else begin
					bnd.has_tail  = 1'b1;
					bnd.tail_kind = cjsd_pkg::KIND_ERR;
					bnd.tail_code = cjsd_pkg::ERR_UTF8;
					phase_d       = PH_IDLE;
				end
			end
			PH_UTF: begin
				ok = (b[7:6] == 2'b10);
				if (seq_idx_q == 2'd1) begin
					if (held_q[7:0] == 8'he0 && b < 8'ha0) ok = 1'b0;
					if (held_q[7:0] == 8'hed && b >= 8'ha0) ok = 1'b0;
					if (held_q[7:0] == 8'hf0 && b < 8'h90) ok = 1'b0;
					if (held_q[7:0] == 8'hf4 && b > 8'h8f) ok = 1'b0;
				end
				if (!ok) begin
					bnd.has_tail  = 1'b1;
					bnd.tail_kind = cjsd_pkg::KIND_ERR;
					bnd.tail_code = cjsd_pkg::ERR_UTF8;
					phase_d       = PH_IDLE;
				end else if (({1'b0, seq_idx_q} + 3'd1) < seq_len_q) begin
					held_d    = {held_q[15:0], b};
					seq_idx_d = seq_idx_q + 2'd1;
				end else if (seq_len_q == 3'd3 && held_q == 24'h00e280 &&
					(b == 8'ha8 || b == 8'ha9)) begin
					bnd.has_tail  = 1'b1;
					bnd.tail_kind = cjsd_pkg::KIND_ERR;
					bnd.tail_code = cjsd_pkg::ERR_RAW_SEP;
					phase_d       = PH_IDLE;
				end else begin
					bnd.n_bytes = seq_len_q;
					case (seq_len_q)
						3'd2: begin
							bnd.bytes[0] = held_q[7:0];
							bnd.bytes[1] = b;
						end
						3'd3: begin
							bnd.bytes[0] = held_q[15:8];
							bnd.bytes[1] = held_q[7:0];
							bnd.bytes[2] = b;
						end
						default: begin
							bnd.bytes[0] = held_q[23:16];
							bnd.bytes[1] = held_q[15:8];
							bnd.bytes[2] = held_q[7:0];
							bnd.bytes[3] = b;
						end
					endcase
					held_d    = '0;
					seq_len_d = '0;
					seq_idx_d = '0;
					phase_d   = PH_STR;
				end
			end
			PH_ESC: begin
				phase_d     = PH_STR;
				bnd.n_bytes = 3'd1;
				case (b)
					8'h22: bnd.bytes[0] = 8'h22;
					8'h5c: bnd.bytes[0] = 8'h5c;
					8'h62: bnd.bytes[0] = 8'h08;
					8'h66: bnd.bytes[0] = 8'h0c;
					8'h6e: bnd.bytes[0] = 8'h0a;
					8'h72: bnd.bytes[0] = 8'h0d;
					8'h74: bnd.bytes[0] = 8'h09;
					8'h75: begin
						bnd.n_bytes = 3'd0;
						hex_d       = '0;
						hex_cnt_d   = '0;
						hex_bad_d   = 1'b0;
						phase_d     = PH_HEX;
					end
					default: begin
						bnd.n_bytes   = 3'd0;
						bnd.has_tail  = 1'b1;
						bnd.tail_kind = cjsd_pkg::KIND_ERR;
						bnd.tail_code = cjsd_pkg::ERR_ESC_CHAR;
						phase_d       = PH_IDLE;
					end
				endcase
			end
			PH_HEX: begin
				if (b >= 8'h30 && b <= 8'h39) begin
					dig    = b[3:0];
					dig_ok = 1'b1;
				end else if (b >= 8'h61 && b <= 8'h66) begin
					dig    = b[3:0] + 4'd9;
					dig_ok = 1'b1;
				end
				hex_bad_d = hex_bad_q | ~dig_ok;
				hex_d     = {hex_q[11:0], dig};
				hex_cnt_d = hex_cnt_q + 3'd1;
				html = hex_d == 16'h003c || hex_d == 16'h003e || hex_d == 16'h0026;
				sep  = hex_d == 16'h2028 || hex_d == 16'h2029;
				ctl  = hex_d < 16'h0020 && hex_d != 16'h0008 && hex_d != 16'h0009 &&
					hex_d != 16'h000a && hex_d != 16'h000c && hex_d != 16'h000d;
				if (hex_cnt_q == 3'd3) begin
					if (hex_bad_d) begin
						bnd.has_tail  = 1'b1;
						bnd.tail_kind = cjsd_pkg::KIND_ERR;
						bnd.tail_code = cjsd_pkg::ERR_HEX_CASE;
						phase_d       = PH_IDLE;
					end else if (!html && !sep && !ctl) begin
						bnd.has_tail  = 1'b1;
						bnd.tail_kind = cjsd_pkg::KIND_ERR;
						bnd.tail_code = cjsd_pkg::ERR_HEX_VALUE;
						phase_d       = PH_IDLE;
					end else begin
						if (hex_d[15:7] == '0) begin
							bnd.n_bytes  = 3'd1;
							bnd.bytes[0] = hex_d[7:0];
						end else if (hex_d[15:11] == '0) begin
							bnd.n_bytes  = 3'd2;
							bnd.bytes[0] = {3'b110, hex_d[10:6]};
							bnd.bytes[1] = {2'b10, hex_d[5:0]};
						end else begin
							bnd.n_bytes  = 3'd3;
							bnd.bytes[0] = {4'b1110, hex_d[15:12]};
							bnd.bytes[1] = {2'b10, hex_d[11:6]};
							bnd.bytes[2] = {2'b10, hex_d[5:0]};
						end
						hex_d     = '0;
						hex_cnt_d = '0;
						phase_d   = PH_STR;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		if (item.buffer_end) begin
			case (phase_d)
				PH_STR: begin
					bnd.has_tail  = 1'b1;
					bnd.tail_kind = cjsd_pkg::KIND_ERR;
					bnd.tail_code = cjsd_pkg::ERR_UNTERM;
				end
				PH_UTF: begin
					bnd.has_tail  = 1'b1;
					bnd.tail_kind = cjsd_pkg::KIND_ERR;
					bnd.tail_code = cjsd_pkg::ERR_UTF8;
				end
				PH_ESC: begin
					bnd.has_tail  = 1'b1;
					bnd.tail_kind = cjsd_pkg::KIND_ERR;
					bnd.tail_code = cjsd_pkg::ERR_ESC_END;
				end
				PH_HEX: begin
					bnd.has_tail  = 1'b1;
					bnd.tail_kind = cjsd_pkg::KIND_ERR;
					bnd.tail_code = cjsd_pkg::ERR_HEX_TRUNC;
				end
				default: begin
				end
			endcase
			phase_d   = PH_WAIT;
			held_d    = '0;
			seq_len_d = '0;
			seq_idx_d = '0;
			hex_d     = '0;
			hex_cnt_d = '0;
			hex_bad_d = 1'b0;
		end
	end

	assign bundle = bnd;
	assign push   = fire && (bnd.n_bytes != 3'd0 || bnd.has_tail);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_WAIT;
			held_q    <= '0;
			seq_len_q <= '0;
			seq_idx_q <= '0;
			hex_q     <= '0;
			hex_cnt_q <= '0;
			hex_bad_q <= 1'b0;
		end else if (fire) begin
			phase_q   <= phase_d;
			held_q    <= held_d;
			seq_len_q <= seq_len_d;
			seq_idx_q <= seq_idx_d;
			hex_q     <= hex_d;
			hex_cnt_q <= hex_cnt_d;
			hex_bad_q <= hex_bad_d;
		end
	end

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.buffer_end |=> phase_q == PH_WAIT)
		else $error("phase not reset after buffer end");

	a_bundle_size: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> bundle.n_bytes <= 3'd4 &&
			!(bundle.has_tail && bundle.tail_kind == cjsd_pkg::KIND_BYTE))
		else $error("malformed result bundle");

endmodule
`default_nettype wire

// ===== rtl/cjsd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cjsd_queue
// Small FIFO of result bundles between the parser and the output serializer.
// ----------------------------------------------------------------------------
module cjsd_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  cjsd_pkg::bundle_t  wr_data,
	input  wire                pop,
	output logic               full,
	output logic               head_valid,
	output cjsd_pkg::bundle_t  head
);

	cjsd_pkg::bundle_t mem_q [cjsd_pkg::QDEPTH];

	logic [cjsd_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [cjsd_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [cjsd_pkg::QCNT_W-1:0] count_q;

	assign full       = count_q == cjsd_pkg::QCNT_W'(cjsd_pkg::QDEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("bundle queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("bundle queue underflow");

endmodule
`default_nettype wire

// ===== rtl/cjsd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cjsd_back
// Output serializer: walks the head bundle one result item per cycle unless stalled.
// ----------------------------------------------------------------------------
module cjsd_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 head_valid,
	input  cjsd_pkg::bundle_t   head,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output cjsd_pkg::out_item_t out_item
);

	logic [2:0]          idx_q;
	logic [2:0]          total;
	logic                is_last;
	logic                load;
	logic                out_valid_q;
	cjsd_pkg::out_item_t out_q;
	cjsd_pkg::out_item_t cur;

	assign total   = head.n_bytes + {2'b00, head.has_tail};
	assign is_last = (idx_q + 3'd1) == total;
	assign load    = head_valid && (!out_valid_q || out_ready);
	assign pop     = load && is_last;

	always_comb begin
		cur          = '0;
		cur.run_last = is_last;
		if (idx_q < head.n_bytes) begin
			cur.kind     = cjsd_pkg::KIND_BYTE;
			cur.out_byte = head.bytes[idx_q[1:0]];
		end else begin
			cur.kind       = head.tail_kind;
			cur.error_code = head.tail_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= is_last ? 3'd0 : idx_q + 3'd1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= cur;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q < total)
		else $error("serializer index beyond bundle");

	a_pop_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == 3'd0)
		else $error("serializer index not rewound after pop");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the canonical JSON string decoder core. Byte
// buffers are fed through the input handshake while a local decoder predicts
// each byte's results (decoded bytes, done, error codes, last-of-item flag).
// Every result taken at the output is compared with the oldest prediction.
// Directed buffers hit each error code and the UTF-8 and escape limits;
// random buffers, mostly well formed, run under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_top;

	typedef enum logic [2:0] {
		SCAN_OPEN, SCAN_TEXT, SCAN_UTF8, SCAN_ESC, SCAN_HEX, SCAN_SKIP
	} scan_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5c;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	cjsd_pkg::in_item_t  in_item = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	cjsd_pkg::out_item_t out_item;

	// decoder model state
	scan_t       scan_st = SCAN_OPEN;
	logic [23:0] utf_held = '0;
	logic [2:0]  utf_len = '0;
	logic [1:0]  utf_idx = '0;
	logic [15:0] hex_acc = '0;
	logic [2:0]  hex_cnt = '0;
	logic        hex_err = 1'b0;

	cjsd_pkg::out_item_t decoded_q[$];
	cjsd_pkg::out_item_t byte_results[$];
	logic [7:0]          frame[$];
	string               esc_letters = "\"\\bfnrt";

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int fed_cnt = 0;
	int mismatch_cnt = 0;

	canonical_json_string_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $time);
		mismatch_cnt++;
	endtask

	task automatic put(input logic [1:0] k, input logic [7:0] b, input logic [3:0] c);
		cjsd_pkg::out_item_t r;
		r.kind = k;
		r.out_byte = b;
		r.error_code = c;
		r.run_last = 1'b0;
		byte_results.insert(byte_results.size(), r);
	endtask

	task automatic abort(input logic [3:0] c);
		put(cjsd_pkg::KIND_ERR, 8'h00, c);
		scan_st = SCAN_SKIP;
	endtask

	task automatic put_codepoint(input logic [15:0] v);
		if (v <= 16'h007f) begin
			put(cjsd_pkg::KIND_BYTE, v[7:0], cjsd_pkg::ERR_NONE);
		end else if (v <= 16'h07ff) begin
			put(cjsd_pkg::KIND_BYTE, {3'b110, v[10:6]}, cjsd_pkg::ERR_NONE);
			put(cjsd_pkg::KIND_BYTE, {2'b10, v[5:0]}, cjsd_pkg::ERR_NONE);
		end else begin
			put(cjsd_pkg::KIND_BYTE, {4'b1110, v[15:12]}, cjsd_pkg::ERR_NONE);
			put(cjsd_pkg::KIND_BYTE, {2'b10, v[11:6]}, cjsd_pkg::ERR_NONE);
			put(cjsd_pkg::KIND_BYTE, {2'b10, v[5:0]}, cjsd_pkg::ERR_NONE);
		end
	endtask

	// Predicts every result one accepted byte causes and queues them.
	task automatic decode_byte(input cjsd_pkg::in_item_t it);
		logic [7:0]          b;
		logic                cont_ok;
		logic [3:0]          d;
		logic [7:0]          esc_val;
		logic                esc_hit;
		logic                html, sep, ctl;
		cjsd_pkg::out_item_t r;
		b = it.data_byte;
		byte_results.delete();
		case (scan_st)
		SCAN_OPEN: begin
			if (b == CH_QUOTE) scan_st = SCAN_TEXT;
			else abort(cjsd_pkg::ERR_NO_QUOTE);
		end
		SCAN_TEXT: begin
			if (b == CH_QUOTE) begin
				put(cjsd_pkg::KIND_DONE, 8'h00, cjsd_pkg::ERR_NONE);
				scan_st = SCAN_SKIP;
			end else if (b == CH_BSL) begin
				scan_st = SCAN_ESC;
			end else if (b < 8'h20 || b == "<" || b == ">" || b == "&") begin
				abort(cjsd_pkg::ERR_RAW_CHAR);
			end else if (b <= 8'h7f) begin
				put(cjsd_pkg::KIND_BYTE, b, cjsd_pkg::ERR_NONE);
			end else if (b >= 8'hc2 && b <= 8'hf4) begin
				utf_len = (b <= 8'hdf) ? 3'd2 : (b <= 8'hef) ? 3'd3 : 3'd4;
				utf_idx = 2'd1;
				utf_held = {16'h0000, b};
				scan_st = SCAN_UTF8;
			end else begin
				abort(cjsd_pkg::ERR_UTF8);
			end
		end
		SCAN_UTF8: begin
			cont_ok = (b >= 8'h80 && b <= 8'hbf);
			if (utf_idx == 2'd1) begin
				if (utf_held[7:0] == 8'he0 && b < 8'ha0) cont_ok = 1'b0;
				if (utf_held[7:0] == 8'hed && b >= 8'ha0) cont_ok = 1'b0;
				if (utf_held[7:0] == 8'hf0 && b < 8'h90) cont_ok = 1'b0;
				if (utf_held[7:0] == 8'hf4 && b > 8'h8f) cont_ok = 1'b0;
			end
			if (!cont_ok) begin
				abort(cjsd_pkg::ERR_UTF8);
			end else if ({1'b0, utf_idx} + 3'd1 < utf_len) begin
				utf_held = {utf_held[15:0], b};
				utf_idx = utf_idx + 2'd1;
			end else if (utf_len == 3'd3 && utf_held == 24'h00e280 &&
				(b == 8'ha8 || b == 8'ha9)) begin
				abort(cjsd_pkg::ERR_RAW_SEP);
			end else begin
				for (int k = utf_len - 1; k > 0; k--)
					put(cjsd_pkg::KIND_BYTE, utf_held[8*(k-1) +: 8], cjsd_pkg::ERR_NONE);
				put(cjsd_pkg::KIND_BYTE, b, cjsd_pkg::ERR_NONE);
				utf_held = '0;
				utf_len = '0;
				utf_idx = '0;
				scan_st = SCAN_TEXT;
			end
		end
		SCAN_ESC: begin
			esc_hit = 1'b1;
			esc_val = b;
			case (b)
			CH_QUOTE, CH_BSL: esc_val = b;
			"b": esc_val = 8'h08;
			"f": esc_val = 8'h0c;
			"n": esc_val = 8'h0a;
			"r": esc_val = 8'h0d;
			"t": esc_val = 8'h09;
			default: esc_hit = 1'b0;
			endcase
			if (esc_hit) begin
				put(cjsd_pkg::KIND_BYTE, esc_val, cjsd_pkg::ERR_NONE);
				scan_st = SCAN_TEXT;
			end else if (b == "u") begin
				hex_acc = '0;
				hex_cnt = '0;
				hex_err = 1'b0;
				scan_st = SCAN_HEX;
			end else begin
				abort(cjsd_pkg::ERR_ESC_CHAR);
			end
		end
		SCAN_HEX: begin
			d = 4'h0;
			if (b >= "0" && b <= "9") d = b[3:0];
			else if (b >= "a" && b <= "f") d = b[3:0] + 4'd9;
			else hex_err = 1'b1;
			hex_acc = {hex_acc[11:0], d};
			hex_cnt = hex_cnt + 3'd1;
			if (hex_cnt >= 3'd4) begin
				html = (hex_acc == 16'h003c || hex_acc == 16'h003e || hex_acc == 16'h0026);
				sep = (hex_acc == 16'h2028 || hex_acc == 16'h2029);
				ctl = (hex_acc < 16'h0020 && hex_acc != 16'h0008 && hex_acc != 16'h0009 &&
					hex_acc != 16'h000a && hex_acc != 16'h000c && hex_acc != 16'h000d);
				if (hex_err) begin
					abort(cjsd_pkg::ERR_HEX_CASE);
				end else if (!(html || sep || ctl)) begin
					abort(cjsd_pkg::ERR_HEX_VALUE);
				end else begin
					put_codepoint(hex_acc);
					hex_acc = '0;
					hex_cnt = '0;
					scan_st = SCAN_TEXT;
				end
			end
		end
		default: scan_st = SCAN_SKIP;
		endcase

		if (it.buffer_end) begin
			case (scan_st)
			SCAN_TEXT: put(cjsd_pkg::KIND_ERR, 8'h00, cjsd_pkg::ERR_UNTERM);
			SCAN_UTF8: put(cjsd_pkg::KIND_ERR, 8'h00, cjsd_pkg::ERR_UTF8);
			SCAN_ESC:  put(cjsd_pkg::KIND_ERR, 8'h00, cjsd_pkg::ERR_ESC_END);
			SCAN_HEX:  put(cjsd_pkg::KIND_ERR, 8'h00, cjsd_pkg::ERR_HEX_TRUNC);
			default: ;
			endcase
			scan_st = SCAN_OPEN;
			utf_held = '0;
			utf_len = '0;
			utf_idx = '0;
			hex_acc = '0;
			hex_cnt = '0;
			hex_err = 1'b0;
		end

		foreach (byte_results[i]) begin
			r = byte_results[i];
			r.run_last = (i == byte_results.size() - 1);
			decoded_q.insert(decoded_q.size(), r);
		end
	endtask

	always @(posedge clk) begin : check_results
		cjsd_pkg::out_item_t want;
		if (in_valid && in_ready)
			decode_byte(in_item);
		if (out_valid && out_ready) begin
			if (decoded_q.size() == 0) begin
				flag_mismatch("unexpected result, kind", int'(out_item.kind), -1);
			end else begin
				want = decoded_q.pop_front();
				if (out_item.kind !== want.kind)
					flag_mismatch("kind", int'(out_item.kind), int'(want.kind));
				if (out_item.out_byte !== want.out_byte)
					flag_mismatch("out_byte", int'(out_item.out_byte), int'(want.out_byte));
				if (out_item.error_code !== want.error_code)
					flag_mismatch("error_code", int'(out_item.error_code),
						int'(want.error_code));
				if (out_item.run_last !== want.run_last)
					flag_mismatch("run_last", int'(out_item.run_last), int'(want.run_last));
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_item <= '{data_byte: b, buffer_end: last};
		do @(posedge clk); while (!in_ready);
	endtask

	// buffer end rides on the last byte of the frame
	task automatic send_frame();
		foreach (frame[i])
			send_byte(frame[i], i == frame.size() - 1);
		fed_cnt += frame.size();
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (decoded_q.size() != 0);
	endtask

	task automatic append_byte(input logic [7:0] v);
		frame.insert(frame.size(), v);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 4'd10) return 8'h30 + n;
		return (upper ? 8'h41 : 8'h61) + n - 8'd10;
	endfunction

	// \u escape; with mix set, digits may come out uppercase or as junk
	task automatic push_uescape(input logic [15:0] cp, input bit mix);
		int r;
		append_byte(CH_BSL);
		append_byte("u");
		for (int i = 3; i >= 0; i--) begin
			r = mix ? $urandom_range(9) : 9;
			if (r == 0) append_byte(8'($urandom_range(255)));
			else append_byte(hex_char(cp[4*i +: 4], r < 3));
		end
	endtask

	task automatic add_token(input bit noisy);
		int         sel;
		logic [7:0] c;
		logic [7:0] lead;
		logic [15:0] cp;
		sel = noisy ? $urandom_range(9, 6) : $urandom_range(5, 0);
		case (sel)
		0: begin
			c = 8'($urandom_range(126, 32));
			if (c == CH_QUOTE || c == CH_BSL || c == "<" || c == ">" || c == "&")
				c = "z";
			append_byte(c);
		end
		1: begin
			append_byte(CH_BSL);
			append_byte(esc_letters[$urandom_range(6)]);
		end
		2: begin
			case ($urandom_range(5))
			0: cp = 16'h003c;
			1: cp = 16'h003e;
			2: cp = 16'h0026;
			3: cp = 16'h2028;
			4: cp = 16'h2029;
			default: begin
				do cp = 16'($urandom_range(31));
				while (cp == 16'h8 || cp == 16'h9 || cp == 16'ha || cp == 16'hc || cp == 16'hd);
			end
			endcase
			push_uescape(cp, 1'b0);
		end
		3: begin
			append_byte(8'($urandom_range(8'hdf, 8'hc2)));
			append_byte(8'($urandom_range(8'hbf, 8'h80)));
		end
		4: begin
			lead = 8'($urandom_range(8'hef, 8'he0));
			append_byte(lead);
			if (lead == 8'he0) append_byte(8'($urandom_range(8'hbf, 8'ha0)));
			else if (lead == 8'hed) append_byte(8'($urandom_range(8'h9f, 8'h80)));
			else append_byte(8'($urandom_range(8'hbf, 8'h80)));
			append_byte(8'($urandom_range(8'hbf, 8'h80)));
		end
		5: begin
			lead = 8'($urandom_range(8'hf4, 8'hf0));
			append_byte(lead);
			if (lead == 8'hf0) append_byte(8'($urandom_range(8'hbf, 8'h90)));
			else if (lead == 8'hf4) append_byte(8'($urandom_range(8'h8f, 8'h80)));
			else append_byte(8'($urandom_range(8'hbf, 8'h80)));
			append_byte(8'($urandom_range(8'hbf, 8'h80)));
			append_byte(8'($urandom_range(8'hbf, 8'h80)));
		end
		6: append_byte(8'($urandom_range(255)));
		7: begin
			append_byte(CH_BSL);
			append_byte(8'($urandom_range(255)));
		end
		8: push_uescape(16'($urandom_range(16'hffff)), 1'b1);
		default: begin
			append_byte(8'($urandom_range(8'hf4, 8'hc2)));
			append_byte(8'($urandom_range(255)));
		end
		endcase
	endtask

	// mostly quoted strings of valid tokens; some open, cut or noisy
	task automatic random_buffer();
		int         cut;
		logic [7:0] c;
		frame.delete();
		c = 8'($urandom_range(255));
		if ($urandom_range(15) != 0) c = CH_QUOTE;
		append_byte(c);
		repeat ($urandom_range(4)) add_token($urandom_range(4) == 0);
		case ($urandom_range(9))
		0, 1: ;
		2, 3: begin
			if (frame.size() > 1) begin
				cut = $urandom_range(frame.size() - 1, 1);
				while (frame.size() > cut) c = frame.pop_back();
			end
		end
		default: begin
			append_byte(CH_QUOTE);
			repeat ($urandom_range(2)) append_byte(8'($urandom_range(255)));
		end
		endcase
		send_frame();
	endtask

	task automatic test_framing();
		frame = '{"x"};
		send_frame();
		frame = '{CH_QUOTE, 8'h20, 8'h7e, CH_QUOTE, "z"};
		send_frame();
		frame = '{CH_QUOTE, "a"};
		send_frame();
	endtask

	task automatic test_raw_text();
		frame = '{CH_QUOTE, 8'h1f};
		send_frame();
		frame = '{CH_QUOTE, ">"};
		send_frame();
		// 2-byte low edge, 4-byte top edge, then buffer ends in the string
		frame = '{CH_QUOTE, 8'hc2, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
		send_frame();
		frame = '{CH_QUOTE, 8'he2, 8'h80, 8'ha9};
		send_frame();
		frame = '{CH_QUOTE, 8'hed, 8'ha0};
		send_frame();
		frame = '{CH_QUOTE, 8'hff};
		send_frame();
		frame = '{CH_QUOTE, 8'he0, 8'ha0};
		send_frame();
	endtask

	task automatic test_escapes();
		frame = '{CH_QUOTE, CH_BSL, "n", CH_BSL, "u", "2", "0", "2", "8", CH_QUOTE};
		send_frame();
		frame = '{CH_QUOTE, CH_BSL};
		send_frame();
		frame = '{CH_QUOTE, CH_BSL, "/"};
		send_frame();
		frame = '{CH_QUOTE, CH_BSL, "u", "0", "0"};
		send_frame();
		frame = '{CH_QUOTE, CH_BSL, "u", "0", "0", "3", "C"};
		send_frame();
		frame = '{CH_QUOTE, CH_BSL, "u", "0", "0", "0", "9"};
		send_frame();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
		input int count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		fed_cnt = 0;
		while (fed_cnt < count) random_buffer();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_framing();
		test_raw_text();
		test_escapes();
		test_random_traffic(0, 0, 8);
		test_random_traffic(72, 0, 8);
		wait_for_results();
		test_random_traffic(0, 72, 8);
		test_random_traffic(7, 7, 8);
		in_valid <= 1'b0;
		recv_stall_pct = 0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (32) @(posedge clk);
		if (mismatch_cnt == 0 && decoded_q.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== canonical_json_string_decoder_core.f =====
rtl/cjsd_pkg.sv
rtl/cjsd_front.sv
rtl/cjsd_queue.sv
rtl/cjsd_back.sv
rtl/canonical_json_string_decoder_core.sv
dv/tb_top.sv
